FILE: hdl/assert_macros.svh
// assertion macros shared by the transcoder rtl
// no dependencies; the checks drop out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define C2U_ASSERT(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("c2u check failed");
`define C2U_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("c2u check failed");
`else
`define C2U_ASSERT(label, clk, rst, cond)
`define C2U_ASSERT_IMP(label, clk, rst, ante, cons)
`endif

`endif

FILE: hdl/c2u_pkg.sv
// types, constants and tables of the cp1251 to utf-8 transcoder
// no dependencies
`default_nettype none

package c2u_pkg;

   localparam int C2U_CMD_DEPTH = 4;

   typedef logic [3:0] match_type;

   localparam match_type PAT_LAST   = 4'd11;
   // "window" is the only prefix with a border ("w")
   localparam match_type BORDER_AT  = 4'd6;
   localparam match_type BORDER_EMIT = 4'd5;
   localparam match_type REPL_LEN   = 4'd5;

   localparam logic [7:0] PAT_BYTES [12] = '{
      8'h77, 8'h69, 8'h6E, 8'h64, 8'h6F, 8'h77, 8'h73, 8'h2D, 8'h31, 8'h32, 8'h35, 8'h31
   };

   localparam logic [7:0] REPL_BYTES [5] = '{8'h55, 8'h54, 8'h46, 8'h2D, 8'h38};

   // code points of bytes 0x80..0xbf
   localparam logic [15:0] HI_MAP [64] = '{
      16'h0402, 16'h0403, 16'h201A, 16'h0453, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
      16'h20AC, 16'h2030, 16'h0409, 16'h2039, 16'h040A, 16'h040C, 16'h040B, 16'h040F,
      16'h0452, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
      16'h0098, 16'h2122, 16'h0459, 16'h203A, 16'h045A, 16'h045C, 16'h045B, 16'h045F,
      16'h00A0, 16'h040E, 16'h045E, 16'h0408, 16'h00A4, 16'h0490, 16'h00A6, 16'h00A7,
      16'h0401, 16'h00A9, 16'h0404, 16'h00AB, 16'h00AC, 16'h00AD, 16'h00AE, 16'h0407,
      16'h00B0, 16'h00B1, 16'h0406, 16'h0456, 16'h0491, 16'h00B5, 16'h00B6, 16'h00B7,
      16'h0451, 16'h2116, 16'h0454, 16'h00BB, 16'h0458, 16'h0405, 16'h0455, 16'h0457
   };

   typedef enum logic [1:0] {
      MID_NONE,
      MID_CONV,
      MID_REPL
   } mid_kind_type;

   typedef struct packed {
      logic [1:0]      len;
      logic [2:0][7:0] bytes;
   } utf8_type;

   // one classified input item: held prefix, border byte, body, flush on last
   typedef struct packed {
      match_type    seg_a;
      logic         seg_b;
      mid_kind_type mid;
      utf8_type     conv;
      match_type    seg_t;
      logic         last;
   } cmd_type;

   function automatic logic [7:0] pat_byte(input match_type i);
      logic [7:0] b;
      b = 8'h00;
      if (i <= PAT_LAST) begin
         b = PAT_BYTES[i];
      end
      return b;
   endfunction

   function automatic logic [7:0] repl_byte(input logic [2:0] i);
      logic [7:0] b;
      b = 8'h00;
      if (i < 3'd5) begin
         b = REPL_BYTES[i];
      end
      return b;
   endfunction

   function automatic utf8_type to_utf8(input logic [7:0] c);
      utf8_type   u;
      logic [15:0] cp;
      u  = '0;
      cp = '0;
      if (!c[7]) begin
         u.len      = 2'd1;
         u.bytes[0] = c;
      end else begin
         if (!c[6]) begin
            cp = HI_MAP[c[5:0]];
         end else begin
            cp = 16'h0410 + {10'd0, c[5:0]};
         end
         if (cp < 16'h0800) begin
            u.len      = 2'd2;
            u.bytes[0] = {3'b110, cp[10:6]};
            u.bytes[1] = {2'b10, cp[5:0]};
         end else begin
            u.len      = 2'd3;
            u.bytes[0] = {4'b1110, cp[15:12]};
            u.bytes[1] = {2'b10, cp[11:6]};
            u.bytes[2] = {2'b10, cp[5:0]};
         end
      end
      return u;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/c2u_cmd_fifo.sv
// short command queue between the classifier and the byte sequencer
// depends on c2u_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module c2u_cmd_fifo
   import c2u_pkg::*;
#(
   parameter int DEPTH = C2U_CMD_DEPTH
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    wr_en,
   input  wire cmd_type wr_cmd,
   output logic         full,
   input  wire logic    rd_en,
   output logic         rd_valid,
   output cmd_type      rd_cmd
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (!wr_en && rd_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

   `C2U_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH))
   `C2U_ASSERT_IMP(a_no_overrun, clock, reset, full && !rd_en, $past(full) || !wr_en)

endmodule

`default_nettype wire

FILE: hdl/c2u_front.sv
// classifier: tracks the partial pattern match and turns each byte that does more than extend it into a command
// depends on c2u_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module c2u_front
   import c2u_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] in_byte,
   input  wire logic       in_last,
   output logic            cmd_push,
   output cmd_type         cmd
);

   match_type match_ff, match_in;
   match_type after_byte;

   always_comb begin
      cmd        = '0;
      cmd.conv   = to_utf8(in_byte);
      after_byte = match_ff;
      if (in_byte == pat_byte(match_ff)) begin
         if (match_ff == PAT_LAST) begin
            cmd.mid    = MID_REPL;
            after_byte = '0;
         end else begin
            after_byte = match_type'(match_ff + 1'b1);
         end
      end else if (match_ff == '0) begin
         cmd.mid = MID_CONV;
      end else if (match_ff == BORDER_AT) begin
         // release "windo", keep "w" and test the byte again
         cmd.seg_a = BORDER_EMIT;
         if (in_byte == pat_byte(4'd1)) begin
            after_byte = 4'd2;
         end else begin
            cmd.seg_b = 1'b1;
            if (in_byte == pat_byte(4'd0)) begin
               after_byte = 4'd1;
            end else begin
               cmd.mid    = MID_CONV;
               after_byte = '0;
            end
         end
      end else begin
         cmd.seg_a = match_ff;
         if (in_byte == pat_byte(4'd0)) begin
            after_byte = 4'd1;
         end else begin
            cmd.mid    = MID_CONV;
            after_byte = '0;
         end
      end
      match_in = after_byte;
      if (in_last) begin
         cmd.seg_t = after_byte;
         cmd.last  = 1'b1;
         match_in  = '0;
      end
      // items that only extend the match, unless last, produce nothing downstream
      cmd_push = accept && ((cmd.seg_a != '0) || cmd.seg_b || (cmd.mid != MID_NONE) ||
                            (cmd.seg_t != '0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= '0;
      end else if (accept) begin
         match_ff <= match_in;
      end
   end

   `C2U_ASSERT(a_match_range, clock, reset, match_ff <= PAT_LAST)

endmodule

`default_nettype wire

FILE: hdl/c2u_back.sv
// byte sequencer: walks the head command one output byte per transfer
// depends on c2u_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module c2u_back
   import c2u_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_valid,
   input  wire cmd_type cmd,
   output logic         cmd_pop,
   output logic         empty,
   input  wire logic    pop,
   output logic [7:0]   out_byte,
   output logic         out_last
);

   typedef enum logic [1:0] {
      PH_HEAD,
      PH_BORDER,
      PH_BODY,
      PH_TAIL
   } phase_type;

   phase_type  phase_ff;
   match_type  idx_ff;
   logic [7:0] byte_ff;
   logic       last_ff;
   logic       valid_ff;

   match_type  plen [4];
   logic [3:0] nonempty;
   logic [1:0] eff;
   logic       later;
   logic       at_end;
   logic       emit;
   logic [7:0] cur_byte;

   always_comb begin
      plen[0] = cmd.seg_a;
      plen[1] = {3'd0, cmd.seg_b};
      case (cmd.mid)
         MID_REPL: plen[2] = REPL_LEN;
         MID_CONV: plen[2] = {2'd0, cmd.conv.len};
         default:  plen[2] = '0;
      endcase
      plen[3] = cmd.seg_t;
      for (int p = 0; p < 4; p++) begin
         nonempty[p] = (plen[p] != '0);
      end
   end

   // skip empty segments starting from the current one
   always_comb begin
      eff   = 2'd3;
      later = 1'b0;
      for (int p = 3; p >= 0; p--) begin
         if ((p >= int'(phase_ff)) && nonempty[p]) begin
            eff = 2'(p);
         end
      end
      for (int p = 0; p < 4; p++) begin
         if ((p > int'(eff)) && nonempty[p]) begin
            later = 1'b1;
         end
      end
   end

   always_comb begin
      unique case (phase_type'(eff))
         PH_HEAD, PH_BORDER, PH_TAIL: cur_byte = pat_byte(idx_ff);
         PH_BODY: begin
            if (cmd.mid == MID_REPL) begin
               cur_byte = repl_byte(idx_ff[2:0]);
            end else begin
               cur_byte = cmd.conv.bytes[idx_ff[1:0]];
            end
         end
      endcase
   end

   assign at_end  = (match_type'(idx_ff + 1'b1) == plen[eff]);
   assign emit    = cmd_valid && (!valid_ff || pop);
   assign cmd_pop = emit && at_end && !later;

   assign empty    = !valid_ff;
   assign out_byte = byte_ff;
   assign out_last = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEAD;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
         byte_ff  <= '0;
         last_ff  <= 1'b0;
      end else begin
         if (emit) begin
            byte_ff  <= cur_byte;
            last_ff  <= cmd.last && at_end && !later;
            valid_ff <= 1'b1;
            if (at_end) begin
               idx_ff <= '0;
               if (later) begin
                  phase_ff <= phase_type'(eff + 2'd1);
               end else begin
                  phase_ff <= PH_HEAD;
               end
            end else begin
               idx_ff   <= match_type'(idx_ff + 1'b1);
               phase_ff <= phase_type'(eff);
            end
         end else if (pop) begin
            valid_ff <= 1'b0;
         end
      end
   end

   `C2U_ASSERT_IMP(a_idx_needs_cmd, clock, reset, idx_ff != '0, cmd_valid)
   `C2U_ASSERT_IMP(a_idx_in_phase, clock, reset, cmd_valid && (idx_ff != '0),
                   (phase_type'(eff) == phase_ff) && (idx_ff < plen[eff]))

endmodule

`default_nettype wire

FILE: hdl/cp1251_to_utf8_transcoder.sv
// an item's command is queued, and its first output byte is then registered at the output
// throughput: one output byte per cycle while the output is popped; an item is emitted
// as a run of bytes (up to three per character, five for the replacement, more when a
// held pattern prefix is released). items that only extend a match, unless last, produce
// no output; a byte is accepted each cycle while the command queue has room. synchronous
// reset clears match and queue. depends on c2u_pkg, c2u_front, c2u_cmd_fifo, c2u_back
`default_nettype none

module cp1251_to_utf8_transcoder
   import c2u_pkg::*;
#(
   parameter int CMD_DEPTH = C2U_CMD_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   output logic            full,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_in_last,
   output logic            empty,
   input  wire logic       pop,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_out_last
);

   logic    accept;
   logic    cmd_push;
   cmd_type cmd_wr;
   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd_head;

   assign accept = push && !full;

   c2u_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .in_byte  (req_in_byte),
      .in_last  (req_in_last),
      .cmd_push (cmd_push),
      .cmd      (cmd_wr)
   );

   c2u_cmd_fifo #(
      .DEPTH (CMD_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (cmd_push),
      .wr_cmd   (cmd_wr),
      .full     (full),
      .rd_en    (cmd_pop),
      .rd_valid (cmd_valid),
      .rd_cmd   (cmd_head)
   );

   c2u_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd_head),
      .cmd_pop   (cmd_pop),
      .empty     (empty),
      .pop       (pop),
      .out_byte  (rsp_out_byte),
      .out_last  (rsp_out_last)
   );

endmodule

`default_nettype wire
